FILE: design/ksme_pkg.sv
// Shared types and constants for the key scan to MIDI event block.
`default_nettype none

package ksme_pkg;

  // Defaults of the top level parameters
  localparam int KEY_COUNT_DEF    = 12;
  localparam int OCTAVE_COUNT_DEF = 3;
  localparam int SAMPLE_BITS_DEF  = 10;

  // Field widths
  localparam int KEY_W      = 12;
  localparam int SAMP_W     = 10;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 8;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 5;
  localparam int KIND_W     = 2;
  localparam int OCT_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT_LOW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT_HIGH   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 4'd7;

  // Configuration reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd10;
  localparam logic [SAMP_W-1:0] DEAD_BAND_RST  = 10'd6;
  localparam logic [SAMP_W-1:0] OCT_LOW_RST    = 10'd40;
  localparam logic [SAMP_W-1:0] OCT_HIGH_RST   = 10'd880;
  localparam logic [NOTE_W-1:0] BASE_NOTE_RST  = 7'd36;
  localparam logic [NOTE_W-1:0] VELOCITY_RST   = 7'd100;
  localparam logic [NOTE_W-1:0] CONTROLLER_RST = 7'd16;
  localparam logic [CHAN_W-1:0] CHANNEL_RST    = 5'd1;

  // Control change always goes out on channel one
  localparam logic [CHAN_W-1:0] CC_CHANNEL = 5'd1;

  typedef enum logic [KIND_W-1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_CTRL     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] number;
    logic [NOTE_W-1:0] value;
  } ev_t;

endpackage

`default_nettype wire

FILE: design/key_scan_to_midi_events_core.sv
// Key scan to MIDI event converter: top level with scan sequencer and config registers.
//
// Usage: one request on the input channel carries a whole scan (key levels,
// expression and octave slider samples, time in ms). The block walks the
// keys in order against the sounding map held in a synchronous memory,
// then checks the expression slider, then the octave slider, and on an
// octave change sweeps the whole map to turn off every sounding note.
// Events leave on the output channel in that order; last_event_o marks
// the final event of a scan. A scan with no events produces no request.
// The map memory is walked one entry per cycle while the output has
// room. in_stall_o stays high until the scan is fully processed and its
// last event sits in the output register. When out_stall_i is held the
// walk pauses at the next event; nothing is lost. Config writes are
// always accepted (cfg_ready_o high) and should happen between scans.
// Reset clears the sounding map and press times, the slider history and
// octave, and loads the register defaults.
`default_nettype none

module key_scan_to_midi_events_core #(
  parameter int KEY_COUNT    = ksme_pkg::KEY_COUNT_DEF,
  parameter int OCTAVE_COUNT = ksme_pkg::OCTAVE_COUNT_DEF,
  parameter int SAMPLE_BITS  = ksme_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ksme_pkg::KEY_W-1:0]      key_levels_i,
  input  logic [ksme_pkg::SAMP_W-1:0]     expression_sample_i,
  input  logic [ksme_pkg::SAMP_W-1:0]     octave_sample_i,
  input  logic [ksme_pkg::TIME_W-1:0]     now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ksme_pkg::KIND_W-1:0]     event_kind_o,
  output logic [ksme_pkg::CHAN_W-1:0]     event_channel_o,
  output logic [ksme_pkg::NOTE_W-1:0]     event_number_o,
  output logic [ksme_pkg::NOTE_W-1:0]     event_value_o,
  output logic                            last_event_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ksme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ksme_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ksme_pkg::*;

  localparam int MAP_DEPTH = KEY_COUNT * OCTAVE_COUNT;
  localparam int KW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int MW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SHIFT     = SAMPLE_BITS - NOTE_W;
  localparam logic [SAMP_W-1:0] SMASK =
    (SAMPLE_BITS >= SAMP_W) ? {SAMP_W{1'b1}} : SAMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [OCT_W-1:0] OCT_MAX = OCT_W'(OCTAVE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYS,
    ST_CTRL,
    ST_OCT,
    ST_FLUSH,
    ST_FIN
  } st_e;

  st_e state_q;
  logic [MW-1:0] cnt_q;

  // config
  logic [DEB_W-1:0]  debounce_q;
  logic [SAMP_W-1:0] dead_band_q;
  logic [SAMP_W-1:0] oct_low_q;
  logic [SAMP_W-1:0] oct_high_q;
  logic [NOTE_W-1:0] base_q;
  logic [NOTE_W-1:0] vel_q;
  logic [NOTE_W-1:0] ctrl_q;
  logic [CHAN_W-1:0] chan_q;

  // slider history and octave
  logic [SAMP_W-1:0] last_expr_q;
  logic [SAMP_W-1:0] last_octs_q;
  logic [OCT_W-1:0]  cur_oct_q;

  // latched scan
  logic [KEY_W-1:0]  keys_q;
  logic [SAMP_W-1:0] expr_q;
  logic [SAMP_W-1:0] octs_q;
  logic [TIME_W-1:0] now_q;

  logic              in_acc;
  logic [KW-1:0]     kidx;
  logic [MW-1:0]     key_addr;
  logic              at_key_end;
  logic              at_map_end;
  logic [KEY_COUNT-1:0] press_vec;
  logic              pressed;
  logic              sounding;
  logic [TIME_W-1:0] press_rd;
  logic [TIME_W-1:0] elapsed;
  logic              on_ok;
  logic              off_ok;
  logic [SAMP_W-1:0] expr_diff;
  logic [SAMP_W-1:0] octs_diff;
  logic              expr_move;
  logic              octs_move;
  logic [OCT_W-1:0]  oct_raw;
  logic [OCT_W-1:0]  oct_sel;
  logic [NOTE_W-1:0] cc_val;

  logic          room;
  logic          push;
  logic          fin;
  ev_t           ev;
  logic          step;
  logic [MW-1:0] map_raddr;
  logic          map_we;
  logic          map_wdata;
  logic [KW-1:0] press_raddr;
  logic          press_we;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_press
    if (k < KEY_W) begin : g_in
      assign press_vec[k] = ~keys_q[k];
    end else begin : g_none
      assign press_vec[k] = 1'b0;
    end
  end

  assign kidx       = cnt_q[KW-1:0];
  assign key_addr   = cnt_q + MW'(KEY_COUNT) * MW'(cur_oct_q);
  assign at_key_end = (cnt_q == MW'(KEY_COUNT - 1));
  assign at_map_end = (cnt_q == MW'(MAP_DEPTH - 1));
  assign pressed    = press_vec[kidx];
  assign elapsed    = now_q - press_rd;
  assign on_ok      = pressed && !sounding && (elapsed > TIME_W'(debounce_q));
  assign off_ok     = !pressed && sounding;

  assign expr_diff = (expr_q > last_expr_q) ? expr_q - last_expr_q : last_expr_q - expr_q;
  assign octs_diff = (octs_q > last_octs_q) ? octs_q - last_octs_q : last_octs_q - octs_q;
  assign expr_move = expr_diff > dead_band_q;
  assign octs_move = octs_diff > dead_band_q;
  assign cc_val    = ~NOTE_W'(expr_q >> SHIFT);

  always_comb begin
    if (octs_q < oct_low_q) begin
      oct_raw = 2'd0;
    end else if (octs_q < oct_high_q) begin
      oct_raw = 2'd1;
    end else begin
      oct_raw = 2'd2;
    end
    oct_sel = (oct_raw > OCT_MAX) ? OCT_MAX : oct_raw;
  end

  always_comb begin
    push        = 1'b0;
    fin         = 1'b0;
    step        = 1'b0;
    map_we      = 1'b0;
    map_wdata   = 1'b0;
    press_we    = 1'b0;
    ev.kind     = EV_NOTE_OFF;
    ev.chan     = chan_q;
    ev.number   = base_q + NOTE_W'(key_addr);
    ev.value    = vel_q;
    map_raddr   = key_addr;
    press_raddr = kidx;
    case (state_q)
      ST_KEYS: begin
        if (on_ok || off_ok) begin
          ev.kind   = on_ok ? EV_NOTE_ON : EV_NOTE_OFF;
          push      = room;
          map_we    = room;
          map_wdata = on_ok;
          press_we  = on_ok && room;
          step      = room;
        end else begin
          step = 1'b1;
        end
        if (step && !at_key_end) begin
          map_raddr   = key_addr + MW'(1);
          press_raddr = kidx + KW'(1);
        end
      end
      ST_CTRL: begin
        ev.kind   = EV_CTRL;
        ev.chan   = CC_CHANNEL;
        ev.number = ctrl_q;
        ev.value  = cc_val;
        push      = expr_move && room;
      end
      ST_OCT: begin
        map_raddr = '0;
      end
      ST_FLUSH: begin
        ev.number = base_q + NOTE_W'(cnt_q);
        if (sounding) begin
          push   = room;
          map_we = room;
          step   = room;
        end else begin
          step = 1'b1;
        end
        map_raddr = (step && !at_map_end) ? cnt_q + MW'(1) : cnt_q;
      end
      ST_FIN: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_expr_q <= '0;
      last_octs_q <= '0;
      cur_oct_q   <= '0;
      debounce_q  <= DEBOUNCE_RST;
      dead_band_q <= DEAD_BAND_RST;
      oct_low_q   <= OCT_LOW_RST;
      oct_high_q  <= OCT_HIGH_RST;
      base_q      <= BASE_NOTE_RST;
      vel_q       <= VELOCITY_RST;
      ctrl_q      <= CONTROLLER_RST;
      chan_q      <= CHANNEL_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEBOUNCE:   debounce_q  <= cfg_data_i[DEB_W-1:0];
          CFG_DEAD_BAND:  dead_band_q <= cfg_data_i[SAMP_W-1:0];
          CFG_OCT_LOW:    oct_low_q   <= cfg_data_i[SAMP_W-1:0];
          CFG_OCT_HIGH:   oct_high_q  <= cfg_data_i[SAMP_W-1:0];
          CFG_BASE_NOTE:  base_q      <= cfg_data_i[NOTE_W-1:0];
          CFG_VELOCITY:   vel_q       <= cfg_data_i[NOTE_W-1:0];
          CFG_CONTROLLER: ctrl_q      <= cfg_data_i[NOTE_W-1:0];
          CFG_CHANNEL:    chan_q      <= cfg_data_i[CHAN_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_KEYS;
          end
        end
        ST_KEYS: begin
          if (step) begin
            if (at_key_end) begin
              cnt_q   <= '0;
              state_q <= ST_CTRL;
            end else begin
              cnt_q <= cnt_q + MW'(1);
            end
          end
        end
        ST_CTRL: begin
          if (!expr_move) begin
            state_q <= ST_OCT;
          end else if (room) begin
            last_expr_q <= expr_q;
            state_q     <= ST_OCT;
          end
        end
        ST_OCT: begin
          if (octs_move) begin
            cur_oct_q   <= oct_sel;
            last_octs_q <= octs_q;
            state_q     <= (oct_sel != cur_oct_q) ? ST_FLUSH : ST_FIN;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FLUSH: begin
          if (step) begin
            if (at_map_end) begin
              cnt_q   <= '0;
              state_q <= ST_FIN;
            end else begin
              cnt_q <= cnt_q + MW'(1);
            end
          end
        end
        ST_FIN: begin
          if (room) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      keys_q <= key_levels_i;
      expr_q <= expression_sample_i & SMASK;
      octs_q <= octave_sample_i & SMASK;
      now_q  <= now_ms_i;
    end
  end

  ksme_store #(
    .KEY_COUNT (KEY_COUNT),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .map_raddr_i   (map_raddr),
    .map_we_i      (map_we),
    .map_wdata_i   (map_wdata),
    .map_rdata_o   (sounding),
    .press_raddr_i (press_raddr),
    .press_we_i    (press_we),
    .press_wdata_i (now_q),
    .press_rdata_o (press_rd)
  );

  ksme_evq u_evq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .ev_i            (ev),
    .fin_i           (fin),
    .room_o          (room),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .event_channel_o (event_channel_o),
    .event_number_o  (event_number_o),
    .event_value_o   (event_value_o),
    .last_event_o    (last_event_o)
  );

endmodule

`default_nettype wire

FILE: design/ksme_store.sv
// Sounding map and press time memories with per-entry valid bits.
`default_nettype none

module ksme_store #(
  parameter int KEY_COUNT = ksme_pkg::KEY_COUNT_DEF,
  parameter int MAP_DEPTH = ksme_pkg::KEY_COUNT_DEF * ksme_pkg::OCTAVE_COUNT_DEF,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1,
  localparam int MW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [MW-1:0]               map_raddr_i,
  input  logic                        map_we_i,
  input  logic                        map_wdata_i,
  output logic                        map_rdata_o,
  input  logic [KW-1:0]               press_raddr_i,
  input  logic                        press_we_i,
  input  logic [ksme_pkg::TIME_W-1:0] press_wdata_i,
  output logic [ksme_pkg::TIME_W-1:0] press_rdata_o
);
  import ksme_pkg::*;

  logic              map_mem [MAP_DEPTH];
  logic [TIME_W-1:0] press_mem [KEY_COUNT];

  logic [MAP_DEPTH-1:0] map_vld_q;
  logic [KEY_COUNT-1:0] press_vld_q;
  logic [MW-1:0]        map_addr_q;
  logic [KW-1:0]        press_addr_q;
  logic                 map_rv_q;
  logic                 press_rv_q;
  logic                 map_rd_q;
  logic [TIME_W-1:0]    press_rd_q;

  // writes go back to the entry read in the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q    <= '0;
      press_vld_q  <= '0;
      map_rv_q     <= 1'b0;
      press_rv_q   <= 1'b0;
      map_addr_q   <= '0;
      press_addr_q <= '0;
    end else begin
      map_addr_q   <= map_raddr_i;
      press_addr_q <= press_raddr_i;
      map_rv_q     <= map_vld_q[map_raddr_i];
      press_rv_q   <= press_vld_q[press_raddr_i];
      if (map_we_i) begin
        map_vld_q[map_addr_q] <= 1'b1;
      end
      if (press_we_i) begin
        press_vld_q[press_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    map_rd_q   <= map_mem[map_raddr_i];
    press_rd_q <= press_mem[press_raddr_i];
    if (map_we_i) begin
      map_mem[map_addr_q] <= map_wdata_i;
    end
    if (press_we_i) begin
      press_mem[press_addr_q] <= press_wdata_i;
    end
  end

  assign map_rdata_o   = map_rv_q & map_rd_q;
  assign press_rdata_o = press_rv_q ? press_rd_q : '0;

endmodule

`default_nettype wire

FILE: design/ksme_evq.sv
// Event holding stage and output register; marks the final event of a scan.
`default_nettype none

module ksme_evq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ksme_pkg::ev_t               ev_i,
  input  logic                        fin_i,
  output logic                        room_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ksme_pkg::KIND_W-1:0] event_kind_o,
  output logic [ksme_pkg::CHAN_W-1:0] event_channel_o,
  output logic [ksme_pkg::NOTE_W-1:0] event_number_o,
  output logic [ksme_pkg::NOTE_W-1:0] event_value_o,
  output logic                        last_event_o
);
  import ksme_pkg::*;

  logic pend_vld_q;
  logic out_vld_q;
  ev_t  pend_q;
  ev_t  out_ev_q;
  logic out_last_q;
  logic out_free;
  logic move;

  assign out_free = !out_vld_q || !out_stall_i;
  assign room_o   = !pend_vld_q || out_free;
  assign move     = out_free && pend_vld_q && (push_i || fin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= move;
      end
      if (push_i && room_o) begin
        pend_vld_q <= 1'b1;
      end else if (fin_i && room_o) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && room_o) begin
      pend_q <= ev_i;
    end
    if (move) begin
      out_ev_q   <= pend_q;
      out_last_q <= fin_i;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_kind_o    = out_ev_q.kind;
  assign event_channel_o = out_ev_q.chan;
  assign event_number_o  = out_ev_q.number;
  assign event_value_o   = out_ev_q.value;
  assign last_event_o    = out_last_q;

endmodule

`default_nettype wire

FILE: tb/sv/midi_event_checker.sv
// Event predictor and scoreboard for the key scan to MIDI event core.
module midi_event_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [ksme_pkg::KEY_W-1:0]      key_levels_i,
  input  logic [ksme_pkg::SAMP_W-1:0]     expression_sample_i,
  input  logic [ksme_pkg::SAMP_W-1:0]     octave_sample_i,
  input  logic [ksme_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [ksme_pkg::KIND_W-1:0]     event_kind_i,
  input  logic [ksme_pkg::CHAN_W-1:0]     event_channel_i,
  input  logic [ksme_pkg::NOTE_W-1:0]     event_number_i,
  input  logic [ksme_pkg::NOTE_W-1:0]     event_value_i,
  input  logic                            last_event_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ksme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ksme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatches_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ksme_pkg::*;

  localparam int KEYS      = KEY_COUNT_DEF;
  localparam int OCTAVES   = OCTAVE_COUNT_DEF;
  localparam int MAP_DEPTH = KEYS * OCTAVES;

  typedef struct packed {
    ev_t  ev;
    logic last;
  } midi_event_t;

  logic [DEB_W-1:0]     debounce_q;
  logic [SAMP_W-1:0]    dead_band_q;
  logic [SAMP_W-1:0]    oct_low_q;
  logic [SAMP_W-1:0]    oct_high_q;
  logic [NOTE_W-1:0]    base_note_q;
  logic [NOTE_W-1:0]    velocity_q;
  logic [NOTE_W-1:0]    controller_q;
  logic [CHAN_W-1:0]    channel_q;

  logic [MAP_DEPTH-1:0] sounding;
  logic [TIME_W-1:0]    press_at [KEYS];
  logic [SAMP_W-1:0]    last_expr;
  logic [SAMP_W-1:0]    last_oct_sample;
  logic [OCT_W-1:0]     octave;

  midi_event_t          expected_events [$];
  int                   mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic queue_event(input kind_e kind, input logic [CHAN_W-1:0] chan,
                             input logic [NOTE_W-1:0] number, input logic [NOTE_W-1:0] value);
    midi_event_t rec;
    rec.ev.kind   = kind;
    rec.ev.chan   = chan;
    rec.ev.number = number;
    rec.ev.value  = value;
    rec.last      = 1'b0;
    expected_events.push_back(rec);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    midi_event_t      want;
    int               n;
    int               idx;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] cc_value;
    logic [OCT_W-1:0]  oct_sel;
    logic [SAMP_W-1:0] expr_delta;
    logic [SAMP_W-1:0] oct_delta;
    if (!rst_ni) begin
      debounce_q      = DEBOUNCE_RST;
      dead_band_q     = DEAD_BAND_RST;
      oct_low_q       = OCT_LOW_RST;
      oct_high_q      = OCT_HIGH_RST;
      base_note_q     = BASE_NOTE_RST;
      velocity_q      = VELOCITY_RST;
      controller_q    = CONTROLLER_RST;
      channel_q       = CHANNEL_RST;
      sounding        = '0;
      press_at        = '{default: '0};
      last_expr       = '0;
      last_oct_sample = '0;
      octave          = '0;
      expected_events.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("event with nothing expected: kind %0d number %0d value %0d",
                 event_kind_i, event_number_i, event_value_i);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.ev.kind, event_kind_i);
          check_field("event_channel", want.ev.chan, event_channel_i);
          check_field("event_number", want.ev.number, event_number_i);
          check_field("event_value", want.ev.value, event_value_i);
          check_field("last_event", want.last, last_event_i);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE:   debounce_q   = cfg_data_i[DEB_W-1:0];
          CFG_DEAD_BAND:  dead_band_q  = cfg_data_i[SAMP_W-1:0];
          CFG_OCT_LOW:    oct_low_q    = cfg_data_i[SAMP_W-1:0];
          CFG_OCT_HIGH:   oct_high_q   = cfg_data_i[SAMP_W-1:0];
          CFG_BASE_NOTE:  base_note_q  = cfg_data_i[NOTE_W-1:0];
          CFG_VELOCITY:   velocity_q   = cfg_data_i[NOTE_W-1:0];
          CFG_CONTROLLER: controller_q = cfg_data_i[NOTE_W-1:0];
          CFG_CHANNEL:    channel_q    = cfg_data_i[CHAN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        n = expected_events.size();
        for (int k = 0; k < KEYS; k++) begin
          idx  = k + KEYS * int'(octave);
          note = base_note_q + NOTE_W'(idx);
          if (!key_levels_i[k] && !sounding[idx] &&
              (now_ms_i - press_at[k]) > TIME_W'(debounce_q)) begin
            queue_event(EV_NOTE_ON, channel_q, note, velocity_q);
            sounding[idx] = 1'b1;
            press_at[k]   = now_ms_i;
          end else if (key_levels_i[k] && sounding[idx]) begin
            queue_event(EV_NOTE_OFF, channel_q, note, velocity_q);
            sounding[idx] = 1'b0;
          end
        end

        expr_delta = (expression_sample_i > last_expr) ? expression_sample_i - last_expr
                                                       : last_expr - expression_sample_i;
        if (expr_delta > dead_band_q) begin
          cc_value = 7'd127 - NOTE_W'(expression_sample_i >> (SAMPLE_BITS_DEF - 7));
          queue_event(EV_CTRL, CC_CHANNEL, controller_q, cc_value);
          last_expr = expression_sample_i;
        end

        oct_delta = (octave_sample_i > last_oct_sample) ? octave_sample_i - last_oct_sample
                                                        : last_oct_sample - octave_sample_i;
        if (oct_delta > dead_band_q) begin
          if (octave_sample_i < oct_low_q) begin
            oct_sel = OCT_W'(0);
          end else if (octave_sample_i < oct_high_q) begin
            oct_sel = OCT_W'(1);
          end else begin
            oct_sel = OCT_W'(2);
          end
          if (int'(oct_sel) > OCTAVES - 1) oct_sel = OCT_W'(OCTAVES - 1);
          if (oct_sel != octave) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
              if (sounding[i]) begin
                queue_event(EV_NOTE_OFF, channel_q, base_note_q + NOTE_W'(i), velocity_q);
                sounding[i] = 1'b0;
              end
            end
          end
          octave          = oct_sel;
          last_oct_sample = octave_sample_i;
        end

        if (expected_events.size() > n) begin
          expected_events[expected_events.size() - 1].last = 1'b1;
        end
      end

      pending_o <= expected_events.size();
    end
  end

endmodule

FILE: tb/sv/tb_key_scan_to_midi_events_core.sv
// Stimulus and verdict for the key scan to MIDI event core.
module tb_key_scan_to_midi_events_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ksme_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_SCANS  = 90;
  localparam int PHASES        = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;

  logic                  clk_i               = 1'b0;
  logic                  rst_ni              = 1'b0;
  logic                  in_valid_i          = 1'b0;
  logic                  in_stall_o;
  logic [KEY_W-1:0]      key_levels_i        = '1;
  logic [SAMP_W-1:0]     expression_sample_i = '0;
  logic [SAMP_W-1:0]     octave_sample_i     = '0;
  logic [TIME_W-1:0]     now_ms_i            = '0;
  logic                  out_valid_o;
  logic                  out_stall_i         = 1'b0;
  logic [KIND_W-1:0]     event_kind_o;
  logic [CHAN_W-1:0]     event_channel_o;
  logic [NOTE_W-1:0]     event_number_o;
  logic [NOTE_W-1:0]     event_value_o;
  logic                  last_event_o;
  logic                  cfg_valid_i         = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i         = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i          = '0;

  int                    mismatches;
  int                    pending;
  logic                  hold_go = 1'b0;

  logic [KEY_W-1:0]      scan_keys;
  logic [SAMP_W-1:0]     scan_expr;
  logic [SAMP_W-1:0]     scan_octave;
  logic [TIME_W-1:0]     scan_time;

  key_scan_to_midi_events_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .key_levels_i        (key_levels_i),
    .expression_sample_i (expression_sample_i),
    .octave_sample_i     (octave_sample_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .event_kind_o        (event_kind_o),
    .event_channel_o     (event_channel_o),
    .event_number_o      (event_number_o),
    .event_value_o       (event_value_o),
    .last_event_o        (last_event_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  midi_event_checker u_event_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .key_levels_i        (key_levels_i),
    .expression_sample_i (expression_sample_i),
    .octave_sample_i     (octave_sample_i),
    .now_ms_i            (now_ms_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .event_kind_i        (event_kind_o),
    .event_channel_i     (event_channel_o),
    .event_number_i      (event_number_o),
    .event_value_i       (event_value_o),
    .last_event_i        (last_event_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: stall patterns of random density, plus one long hold-off
  initial begin : receiver
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // leaves in_valid_i high; the caller lowers it
  task automatic send_scan(input logic [KEY_W-1:0] keys, input logic [SAMP_W-1:0] expr,
                           input logic [SAMP_W-1:0] octs, input logic [TIME_W-1:0] now);
    in_valid_i          <= 1'b1;
    key_levels_i        <= keys;
    expression_sample_i <= expr;
    octave_sample_i     <= octs;
    now_ms_i            <= now;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // wait until every expected event is out and any silent scan has finished
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned deb, input int unsigned dead,
                                input int unsigned low, input int unsigned high,
                                input int unsigned base, input int unsigned vel,
                                input int unsigned ctrl, input int unsigned chan);
    settle();
    write_cfg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    write_cfg(CFG_DEAD_BAND, CFG_DATA_W'(dead));
    write_cfg(CFG_OCT_LOW, CFG_DATA_W'(low));
    write_cfg(CFG_OCT_HIGH, CFG_DATA_W'(high));
    write_cfg(CFG_BASE_NOTE, CFG_DATA_W'(base));
    write_cfg(CFG_VELOCITY, CFG_DATA_W'(vel));
    write_cfg(CFG_CONTROLLER, CFG_DATA_W'(ctrl));
    write_cfg(CFG_CHANNEL, CFG_DATA_W'(chan));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small key changes and slider drift, some jumps and noise
  task automatic run_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      for (int b = 0; b < burst && left > 0; b++) begin
        case ($urandom_range(0, 9))
          0: scan_keys = KEY_W'($urandom);
          1, 2, 3, 4: scan_keys = scan_keys ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
          5, 6: begin
            scan_keys = scan_keys ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
            scan_keys = scan_keys ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
          end
          default: ;
        endcase
        case ($urandom_range(0, 7))
          0: scan_expr = '0;
          1: scan_expr = '1;
          2: scan_expr = SAMP_W'($urandom);
          default: scan_expr = scan_expr + SAMP_W'($urandom_range(0, 30)) - SAMP_W'(15);
        endcase
        case ($urandom_range(0, 9))
          0: scan_octave = '0;
          1: scan_octave = '1;
          2, 3: scan_octave = SAMP_W'($urandom);
          default: scan_octave = scan_octave + SAMP_W'($urandom_range(0, 6)) - SAMP_W'(3);
        endcase
        if ($urandom_range(0, 19) == 0) begin
          scan_time = $urandom;
        end else begin
          scan_time = scan_time + TIME_W'($urandom_range(0, 40));
        end
        send_scan(scan_keys, scan_expr, scan_octave, scan_time);
        left--;
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults
    send_scan(12'hFFF, 10'd0, 10'd0, 32'd100);
    send_scan(12'h000, 10'd0, 10'd0, 32'd200);
    send_scan(12'h000, 10'd0, 10'd0, 32'd205);
    send_scan(12'hFFF, 10'd0, 10'd0, 32'd206);
    // inside and just past the debounce window
    send_scan(12'hFFE, 10'd0, 10'd0, 32'd210);
    send_scan(12'hFFE, 10'd0, 10'd0, 32'd211);
    // expression slider: full scale, inside dead band, just outside it, back to zero
    send_scan(12'hFFE, 10'h3FF, 10'd0, 32'd212);
    send_scan(12'hFFE, 10'h3F9, 10'd0, 32'd213);
    send_scan(12'hFFE, 10'h3F8, 10'd0, 32'd214);
    send_scan(12'hFFE, 10'd0, 10'd0, 32'd215);
    // octave changes sweep the sounding map
    send_scan(12'hFFE, 10'd0, 10'd40, 32'd216);
    send_scan(12'h555, 10'd0, 10'd40, 32'd300);
    send_scan(12'h555, 10'd0, 10'h3FF, 32'd301);
    send_scan(12'hAAA, 10'd0, 10'h3FF, 32'd400);
    send_scan(12'hFFF, 10'd0, 10'd879, 32'd401);
    send_scan(12'hFFF, 10'd0, 10'd39, 32'd402);
    // elapsed time across the 32-bit wrap
    send_scan(12'h7FF, 10'd0, 10'd39, 32'hFFFF_FFF0);
    send_scan(12'hFFF, 10'd0, 10'd39, 32'hFFFF_FFF8);
    send_scan(12'h7FF, 10'd0, 10'd39, 32'h0000_0000);
    send_scan(12'hFFF, 10'd0, 10'd39, 32'h0000_0005);

    scan_keys   = 12'hFFF;
    scan_expr   = 10'd0;
    scan_octave = 10'd39;
    scan_time   = 32'd5;

    // no debounce, no dead band, notes past 127 wrap
    apply_settings(0, 0, 0, 1023, 127, 127, 127, 16);
    hold_go <= 1'b1;
    run_random(RANDOM_SCANS / PHASES);

    // longest debounce, sliders never act, channel zero
    apply_settings(255, 1023, 1023, 0, 0, 0, 0, 0);
    run_random(RANDOM_SCANS / PHASES);

    // crossed thresholds, channel beyond sixteen
    apply_settings(20, 30, 900, 100, 100, 64, 7, 31);
    write_cfg(CFG_UNUSED, 10'h3FF);
    cfg_valid_i <= 1'b0;
    run_random(RANDOM_SCANS / PHASES);

    apply_settings($urandom_range(0, 1023), $urandom_range(0, 63), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
    run_random(RANDOM_SCANS / PHASES);

    apply_settings(DEBOUNCE_RST, DEAD_BAND_RST, OCT_LOW_RST, OCT_HIGH_RST, BASE_NOTE_RST,
                   VELOCITY_RST, CONTROLLER_RST, CHANNEL_RST);
    run_random(RANDOM_SCANS / PHASES);

    apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
    run_random(RANDOM_SCANS - (PHASES - 1) * (RANDOM_SCANS / PHASES));

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
